// ===== rtl/rwsc_pkg.sv =====
// Shared constants, codes and control types of the ray and wall segment clipper.
`timescale 1ns / 1ps
`default_nettype none
package rwsc_pkg;

	localparam int MAX_WALLS  = 64;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 8;

	localparam logic CMD_ADD_WALL = 1'b0;
	localparam logic CMD_CAST_RAY = 1'b1;

	typedef enum logic [1:0] {
		ST_NO_HIT  = 2'd0,
		ST_CLIPPED = 2'd1,
		ST_STORED  = 2'd2,
		ST_FULL    = 2'd3
	} rwsc_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_WALL,
		S_RD,
		S_DIFF,
		S_MUL,
		S_SUB,
		S_TEST,
		S_DIV,
		S_UPD,
		S_DONE
	} rwsc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic wr_wall;
		logic wall_full;
		logic diff;
		logic mul;
		logic sub;
		logic test;
		logic div_step;
		logic upd;
		logic load_out;
	} rwsc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_ray;
		logic hit;
		logic out_free;
	} rwsc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rwsc_req_if.sv =====
// Input channel: one add-wall or cast-ray beat.
`timescale 1ns / 1ps
`default_nettype none
interface rwsc_req_if #(
	parameter int COORD_BITS = rwsc_pkg::COORD_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/rwsc_rsp_if.sv =====
// Output channel: one result beat.
`timescale 1ns / 1ps
`default_nettype none
interface rwsc_rsp_if #(
	parameter int COORD_BITS = rwsc_pkg::COORD_BITS,
	parameter int FRAC_BITS  = rwsc_pkg::FRAC_BITS
) ();
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             status;
	logic signed [COORD_BITS+FRAC_BITS-1:0] ray_end_x;
	logic signed [COORD_BITS+FRAC_BITS-1:0] ray_end_y;

	modport source (output valid, status, ray_end_x, ray_end_y, input ready);
	modport sink   (input valid, status, ray_end_x, ray_end_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/rwsc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module rwsc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/rwsc_datapath.sv =====
// Datapath: input latch, wall table, intersection test, shift-add divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module rwsc_datapath #(
	parameter int MAX_WALLS  = rwsc_pkg::MAX_WALLS,
	parameter int COORD_BITS = rwsc_pkg::COORD_BITS,
	parameter int FRAC_BITS  = rwsc_pkg::FRAC_BITS,
	localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1,
	localparam int CB = COORD_BITS,
	localparam int EW = COORD_BITS + FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rwsc_pkg::rwsc_cmd_t  cmd,
	output rwsc_pkg::rwsc_stat_t      stat,
	input  wire logic [AW-1:0]        wall_addr,
	input  wire logic                 in_command,
	input  wire logic signed [CB-1:0] in_start_x,
	input  wire logic signed [CB-1:0] in_start_y,
	input  wire logic signed [CB-1:0] in_end_x,
	input  wire logic signed [CB-1:0] in_end_y,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                out_status,
	output logic signed [EW-1:0]      out_x,
	output logic signed [EW-1:0]      out_y
);
	localparam int FB = FRAC_BITS;
	localparam int SW = EW + 1;           // ray direction
	localparam int DW = CB + 1;           // wall direction, origin offset
	localparam int PW = SW + DW;          // mixed products
	localparam int QW = 2 * DW;           // wall-only products
	localparam int NW = 2 * CB + FB + 3;  // den, snum, tnum
	localparam int RW = NW + 2;           // divider partial remainder

	logic                 cmd_q;
	logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [EW-1:0] ex_q, ey_q, ox, oy;
	logic                 hit_any_q;
	logic [4*CB-1:0]      rdata;
	logic signed [CB-1:0] wx0, wy0, wx1, wy1;

	logic signed [SW-1:0] s1x_q, s1y_q;
	logic signed [DW-1:0] s2x_q, s2y_q, dx_q, dy_q;
	logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [QW-1:0] p5_q, p6_q;
	logic signed [NW-1:0] den_q, snum_q, tn_q;
	logic [NW-1:0]        dabs_q, tabs_q;
	logic [EW-1:0]        sxa_q, sya_q, qx_q, qy_q;
	logic [NW-1:0]        rx_q, ry_q;
	logic                 sxn_q, syn_q;
	logic                 den_pos, den_neg, hit;
	logic [NW+1:0]        stx, sty;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic signed [EW-1:0] out_x_q, out_y_q;

	function automatic logic [NW+1:0] div_step(input logic [NW-1:0] r, input logic b,
			input logic [NW-1:0] t, input logic [NW-1:0] d);
		logic [RW-1:0] rs, d1, d2, rn;
		logic [1:0]    k;
		rs = {1'b0, r, 1'b0} + (b ? RW'(t) : '0);
		d1 = RW'(d);
		d2 = d1 << 1;
		if (rs >= d2) begin
			rn = rs - d2;
			k  = 2'd2;
		end else if (rs >= d1) begin
			rn = rs - d1;
			k  = 2'd1;
		end else begin
			rn = rs;
			k  = 2'd0;
		end
		return {rn[NW-1:0], k};
	endfunction

	rwsc_ram #(.WIDTH(4 * CB), .DEPTH(MAX_WALLS)) u_table (
		.clk   (clk),
		.we    (cmd.wr_wall),
		.addr  (wall_addr),
		.wdata ({by_q, bx_q, ay_q, ax_q}),
		.rdata (rdata)
	);

	assign wx0 = rdata[CB-1:0];
	assign wy0 = rdata[2*CB-1:CB];
	assign wx1 = rdata[3*CB-1:2*CB];
	assign wy1 = rdata[4*CB-1:3*CB];
	assign ox  = {ax_q, {FB{1'b0}}};
	assign oy  = {ay_q, {FB{1'b0}}};

	// strict hit, sign of den folded into the bounds
	always_comb begin
		den_neg = den_q[NW-1];
		den_pos = !den_q[NW-1] && (den_q != '0);
		if (den_pos) begin
			hit = !snum_q[NW-1] && (snum_q != '0) && (snum_q < den_q)
				&& !tn_q[NW-1] && (tn_q != '0) && (tn_q < den_q);
		end else if (den_neg) begin
			hit = snum_q[NW-1] && (snum_q > den_q) && tn_q[NW-1] && (tn_q > den_q);
		end else begin
			hit = 1'b0;
		end
	end

	assign stx = div_step(rx_q, sxa_q[EW-1], tabs_q, dabs_q);
	assign sty = div_step(ry_q, sya_q[EW-1], tabs_q, dabs_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= in_command;
			ax_q  <= in_start_x;
			ay_q  <= in_start_y;
			bx_q  <= in_end_x;
			by_q  <= in_end_y;
			ex_q  <= {in_end_x, {FB{1'b0}}};
			ey_q  <= {in_end_y, {FB{1'b0}}};
		end
		if (cmd.diff) begin
			s1x_q <= SW'(ex_q) - SW'(ox);
			s1y_q <= SW'(ey_q) - SW'(oy);
			s2x_q <= DW'(wx1) - DW'(wx0);
			s2y_q <= DW'(wy1) - DW'(wy0);
			dx_q  <= DW'(ax_q) - DW'(wx0);
			dy_q  <= DW'(ay_q) - DW'(wy0);
		end
		if (cmd.mul) begin
			p1_q <= PW'(s1x_q) * PW'(s2y_q);
			p2_q <= PW'(s1y_q) * PW'(s2x_q);
			p3_q <= PW'(s1x_q) * PW'(dy_q);
			p4_q <= PW'(s1y_q) * PW'(dx_q);
			p5_q <= QW'(s2x_q) * QW'(dy_q);
			p6_q <= QW'(s2y_q) * QW'(dx_q);
		end
		if (cmd.sub) begin
			den_q  <= NW'(p1_q) - NW'(p2_q);
			snum_q <= NW'(p3_q) - NW'(p4_q);
			tn_q   <= (NW'(p5_q) - NW'(p6_q)) <<< FB;
		end
		if (cmd.test) begin
			dabs_q <= den_neg ? -den_q : den_q;
			tabs_q <= den_neg ? -tn_q : tn_q;
			sxa_q  <= s1x_q[SW-1] ? EW'(-s1x_q) : EW'(s1x_q);
			sya_q  <= s1y_q[SW-1] ? EW'(-s1y_q) : EW'(s1y_q);
			sxn_q  <= s1x_q[SW-1];
			syn_q  <= s1y_q[SW-1];
			rx_q   <= '0;
			ry_q   <= '0;
			qx_q   <= '0;
			qy_q   <= '0;
		end
		if (cmd.div_step) begin
			rx_q  <= stx[NW+1:2];
			ry_q  <= sty[NW+1:2];
			qx_q  <= (qx_q << 1) + EW'(stx[1:0]);
			qy_q  <= (qy_q << 1) + EW'(sty[1:0]);
			sxa_q <= sxa_q << 1;
			sya_q <= sya_q << 1;
		end
		if (cmd.upd) begin
			ex_q <= sxn_q ? ox - qx_q : ox + qx_q;
			ey_q <= syn_q ? oy - qy_q : oy + qy_q;
		end
		if (cmd.load_out) begin
			if (cmd_q == rwsc_pkg::CMD_ADD_WALL) begin
				out_status_q <= cmd.wall_full ? rwsc_pkg::ST_FULL : rwsc_pkg::ST_STORED;
				out_x_q      <= '0;
				out_y_q      <= '0;
			end else begin
				out_status_q <= hit_any_q ? rwsc_pkg::ST_CLIPPED : rwsc_pkg::ST_NO_HIT;
				out_x_q      <= ex_q;
				out_y_q      <= ey_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_any_q   <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				hit_any_q <= 1'b0;
			end else if (cmd.upd) begin
				hit_any_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.is_ray   = (cmd_q == rwsc_pkg::CMD_CAST_RAY);
	assign stat.hit      = hit;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
endmodule
`default_nettype wire

// ===== rtl/rwsc_ctrl.sv =====
// Controller: item sequencing, wall count, wall walk and divider step count.
`timescale 1ns / 1ps
`default_nettype none
module rwsc_ctrl #(
	parameter int MAX_WALLS  = rwsc_pkg::MAX_WALLS,
	parameter int COORD_BITS = rwsc_pkg::COORD_BITS,
	parameter int FRAC_BITS  = rwsc_pkg::FRAC_BITS,
	localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rwsc_pkg::rwsc_stat_t stat,
	output rwsc_pkg::rwsc_cmd_t       cmd,
	output logic [AW-1:0]             wall_addr
);
	localparam int CW  = $clog2(MAX_WALLS + 1);
	localparam int EW  = COORD_BITS + FRAC_BITS;
	localparam int SCW = $clog2(EW);

	rwsc_pkg::rwsc_state_t state_q, state_d;
	logic [CW-1:0]  count_q, idx_q;
	logic [SCW-1:0] step_q;
	logic           full_q;
	logic           last;

	assign last     = (idx_q + CW'(1)) == count_q;
	assign in_ready = (state_q == rwsc_pkg::S_IDLE);
	assign wall_addr = (state_q == rwsc_pkg::S_WALL) ? count_q[AW-1:0] : idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwsc_pkg::S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			step_q  <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rwsc_pkg::S_START: begin
					idx_q <= '0;
				end
				rwsc_pkg::S_WALL: begin
					full_q <= (count_q == CW'(MAX_WALLS));
					if (count_q != CW'(MAX_WALLS)) begin
						count_q <= count_q + CW'(1);
					end
				end
				rwsc_pkg::S_TEST: begin
					step_q <= '0;
					if (!stat.hit) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				rwsc_pkg::S_DIV: begin
					step_q <= step_q + SCW'(1);
				end
				rwsc_pkg::S_UPD: begin
					idx_q <= idx_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.wall_full = full_q;
		case (state_q)
			rwsc_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = rwsc_pkg::S_START;
				end
			end
			rwsc_pkg::S_START: begin
				if (!stat.is_ray) begin
					state_d = rwsc_pkg::S_WALL;
				end else if (count_q == '0) begin
					state_d = rwsc_pkg::S_DONE;
				end else begin
					state_d = rwsc_pkg::S_RD;
				end
			end
			rwsc_pkg::S_WALL: begin
				cmd.wr_wall = (count_q != CW'(MAX_WALLS));
				state_d     = rwsc_pkg::S_DONE;
			end
			rwsc_pkg::S_RD: begin
				state_d = rwsc_pkg::S_DIFF;
			end
			rwsc_pkg::S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = rwsc_pkg::S_MUL;
			end
			rwsc_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = rwsc_pkg::S_SUB;
			end
			rwsc_pkg::S_SUB: begin
				cmd.sub = 1'b1;
				state_d = rwsc_pkg::S_TEST;
			end
			rwsc_pkg::S_TEST: begin
				cmd.test = 1'b1;
				if (stat.hit) begin
					state_d = rwsc_pkg::S_DIV;
				end else if (last) begin
					state_d = rwsc_pkg::S_DONE;
				end else begin
					state_d = rwsc_pkg::S_RD;
				end
			end
			rwsc_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == SCW'(EW - 1)) begin
					state_d = rwsc_pkg::S_UPD;
				end
			end
			rwsc_pkg::S_UPD: begin
				cmd.upd = 1'b1;
				state_d = last ? rwsc_pkg::S_DONE : rwsc_pkg::S_RD;
			end
			rwsc_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = rwsc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rwsc_pkg::S_IDLE;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WALLS))
		else $error("wall count beyond table depth");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rwsc_pkg::S_DIFF || state_q == rwsc_pkg::S_TEST
			|| state_q == rwsc_pkg::S_UPD) |-> (idx_q < count_q))
		else $error("wall walk past stored walls");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rwsc_pkg::S_DIV) |-> (step_q < SCW'(EW)))
		else $error("divider ran too many steps");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over an untaken beat");
endmodule
`default_nettype wire

// ===== rtl/ray_wall_segment_clipper.sv =====
// Top level of the ray and wall segment clipper.
//
//   channel  dir  beat carries
//   req      in   command, start_x, start_y, end_x, end_y
//   rsp      out  status, ray_end_x, ray_end_y
//
// Add-wall: START, WALL, then DONE loads the result register. Cast-ray:
// START, then for each stored wall RD, DIFF, MUL, SUB and TEST; a hit adds
// the DIV steps and UPD. An empty table goes from START straight to DONE.
// DIV runs the one-bit-a-step shift-add divider.
// One item at a time; req.ready is high only while idle.
// The result register holds a beat until taken; the next item may be accepted
// meanwhile but waits in its last state, so further accepts are delayed.
// arst_n clears control state and the wall count; the table needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module ray_wall_segment_clipper #(
	parameter int MAX_WALLS  = rwsc_pkg::MAX_WALLS,
	parameter int COORD_BITS = rwsc_pkg::COORD_BITS,
	parameter int FRAC_BITS  = rwsc_pkg::FRAC_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rwsc_req_if.sink  req,
	rwsc_rsp_if.source rsp
);
	localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

	rwsc_pkg::rwsc_cmd_t  cmd;
	rwsc_pkg::rwsc_stat_t stat;
	logic [AW-1:0]        wall_addr;

	// sequencer: count, walk index, divider steps
	rwsc_ctrl #(
		.MAX_WALLS  (MAX_WALLS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.stat      (stat),
		.cmd       (cmd),
		.wall_addr (wall_addr)
	);

	// arithmetic, wall table and result register
	rwsc_datapath #(
		.MAX_WALLS  (MAX_WALLS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.wall_addr  (wall_addr),
		.in_command (req.command),
		.in_start_x (req.start_x),
		.in_start_y (req.start_y),
		.in_end_x   (req.end_x),
		.in_end_y   (req.end_y),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_x      (rsp.ray_end_x),
		.out_y      (rsp.ray_end_y)
	);
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench of the ray and wall segment clipper: random wall tables and rays checked against a fixed-point predictor.
`timescale 1ns / 1ps
`default_nettype none

class clip_scoreboard;
	// predictor state: the wall table and the count of stored walls
	logic signed [11:0] wall_x0[64], wall_y0[64], wall_x1[64], wall_y1[64];
	int unsigned        wall_cnt;
	logic [1:0]         exp_status[$];
	logic [19:0]        exp_x[$], exp_y[$];
	int unsigned        errors;

	function new();
		wall_cnt = 0;
		errors   = 0;
	endfunction

	// tnum * s / den truncated toward zero (tnum, den positive)
	function automatic longint clip_offset(longint tnum, longint s, longint den);
		logic [127:0] prod;
		logic [127:0] mag;
		prod = 128'(tnum) * 128'(s < 0 ? -s : s);
		mag  = prod / 128'(den);
		return s < 0 ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	function void queue_expect(logic [1:0] st, logic [19:0] x, logic [19:0] y);
		exp_status = {exp_status, st};
		exp_x      = {exp_x, x};
		exp_y      = {exp_y, y};
	endfunction

	function void note_request(logic cmd, logic signed [11:0] ax, logic signed [11:0] ay,
			logic signed [11:0] bx, logic signed [11:0] by);
		longint ox, oy, ex, ey, s1x, s1y, s2x, s2y, dx, dy, den, snum, tnum;
		bit     hit;
		if (cmd == rwsc_pkg::CMD_ADD_WALL) begin
			if (wall_cnt < 64) begin
				wall_x0[wall_cnt[5:0]] = ax;
				wall_y0[wall_cnt[5:0]] = ay;
				wall_x1[wall_cnt[5:0]] = bx;
				wall_y1[wall_cnt[5:0]] = by;
				wall_cnt++;
				queue_expect(rwsc_pkg::ST_STORED, 20'd0, 20'd0);
			end else begin
				queue_expect(rwsc_pkg::ST_FULL, 20'd0, 20'd0);
			end
			return;
		end
		ox  = longint'(ax) * 256;
		oy  = longint'(ay) * 256;
		ex  = longint'(bx) * 256;
		ey  = longint'(by) * 256;
		hit = 0;
		for (int n = 0; n < wall_cnt; n++) begin
			s1x  = ex - ox;
			s1y  = ey - oy;
			s2x  = longint'(wall_x1[n[5:0]]) - wall_x0[n[5:0]];
			s2y  = longint'(wall_y1[n[5:0]]) - wall_y0[n[5:0]];
			dx   = longint'(ax) - wall_x0[n[5:0]];
			dy   = longint'(ay) - wall_y0[n[5:0]];
			den  = s1x * s2y - s2x * s1y;
			snum = s1x * dy - s1y * dx;
			tnum = (s2x * dy - s2y * dx) * 256;
			// parallel or degenerate: skip this wall
			if (den == 0)
				continue;
			if (den < 0) begin
				den  = -den;
				snum = -snum;
				tnum = -tnum;
			end
			// strict test: touching either end is a miss
			if (snum > 0 && snum < den && tnum > 0 && tnum < den) begin
				ex  = ox + clip_offset(tnum, s1x, den);
				ey  = oy + clip_offset(tnum, s1y, den);
				hit = 1;
			end
		end
		queue_expect(hit ? rwsc_pkg::ST_CLIPPED : rwsc_pkg::ST_NO_HIT, ex[19:0], ey[19:0]);
	endfunction

	function void check_result(logic [1:0] st, logic [19:0] rx, logic [19:0] ry);
		logic [1:0]  es;
		logic [19:0] ex, ey;
		if (exp_status.size() == 0) begin
			$error("result beat with nothing expected: status %0d", st);
			errors++;
			return;
		end
		es = exp_status.pop_front();
		ex = exp_x.pop_front();
		ey = exp_y.pop_front();
		if (st !== es) begin
			$error("status: expected %0d, actual %0d", es, st);
			errors++;
		end
		if (rx !== ex) begin
			$error("ray_end_x: expected %0h, actual %0h", ex, rx);
			errors++;
		end
		if (ry !== ey) begin
			$error("ray_end_y: expected %0h, actual %0h", ey, ry);
			errors++;
		end
	endfunction

	function int pending();
		return exp_status.size();
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;

	rwsc_req_if req ();
	rwsc_rsp_if rsp ();

	ray_wall_segment_clipper dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	clip_scoreboard sb = new();

	// receiver stall control; long_hold forces a long stall in the pressure phase
	bit long_hold;
	bit stim_done;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Send one beat, holding it until accepted. Valid drops only for a gap.
	int unsigned burst_left;

	task automatic send_beat(logic cmd, logic signed [11:0] ax, logic signed [11:0] ay,
			logic signed [11:0] bx, logic signed [11:0] by);
		int unsigned gap;
		// bursts of random length separated by random gaps
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid   <= 1'b1;
		req.command <= cmd;
		req.start_x <= ax;
		req.start_y <= ay;
		req.end_x   <= bx;
		req.end_y   <= by;
		do @(posedge clk); while (!(req.valid && req.ready));
		sb.note_request(cmd, ax, ay, bx, by);
	endtask

	function automatic logic signed [11:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 12'sh800;
			1: return 12'sh7FF;
			2: return 12'($urandom_range(0, 4095));
			default: return 12'($signed($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	// Receiver: stall pattern of its own plus the long hold-off.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.status, rsp.ray_end_x, rsp.ray_end_y);
			if (long_hold)
				rsp.ready <= 1'b0;
			else if (stim_done)
				rsp.ready <= 1'b1;
			else
				rsp.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
		end
	end

	// Long receiver hold-off, counted in cycles while the sender keeps offering.
	task automatic hold_receiver(int unsigned cycles);
		long_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		long_hold = 1'b0;
	endtask

	initial begin
		int unsigned quiet;
		long_hold   = 1'b0;
		stim_done   = 1'b0;
		burst_left  = 0;
		clk         = 1'b0;
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.command = rwsc_pkg::CMD_ADD_WALL;
		req.start_x = '0;
		req.start_y = '0;
		req.end_x   = '0;
		req.end_y   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ray with empty table, then a cross of walls.
		send_beat(rwsc_pkg::CMD_CAST_RAY, 12'sh800, 12'sh800, 12'sh7FF, 12'sh7FF);
		send_beat(rwsc_pkg::CMD_ADD_WALL, 12'sd0, -12'sd100, 12'sd0, 12'sd100);
		send_beat(rwsc_pkg::CMD_ADD_WALL, 12'sd50, -12'sd100, 12'sd50, 12'sd100);
		// zero-length wall
		send_beat(rwsc_pkg::CMD_ADD_WALL, -12'sd50, -12'sd50, -12'sd50, -12'sd50);
		send_beat(rwsc_pkg::CMD_ADD_WALL, 12'sh800, 12'sh7FF, 12'sh7FF, 12'sh800);
		// clipped twice
		send_beat(rwsc_pkg::CMD_CAST_RAY, -12'sd100, 12'sd3, 12'sd100, 12'sd7);
		// clipped, hits the diagonal
		send_beat(rwsc_pkg::CMD_CAST_RAY, -12'sd100, 12'sd0, 12'sd100, 12'sd0);
		// parallel to x=0 wall
		send_beat(rwsc_pkg::CMD_CAST_RAY, 12'sd10, -12'sd100, 12'sd10, 12'sd100);
		// touches wall end
		send_beat(rwsc_pkg::CMD_CAST_RAY, -12'sd10, 12'sd100, 12'sd10, 12'sd100);
		// origin on wall
		send_beat(rwsc_pkg::CMD_CAST_RAY, 12'sd0, 12'sd0, 12'sd30, 12'sd0);
		// ray end on wall
		send_beat(rwsc_pkg::CMD_CAST_RAY, -12'sd100, 12'sd5, 12'sd0, 12'sd5);
		// zero-length ray
		send_beat(rwsc_pkg::CMD_CAST_RAY, 12'sd5, 12'sd5, 12'sd5, 12'sd5);
		send_beat(rwsc_pkg::CMD_CAST_RAY, 12'sh7FF, 12'sh800, 12'sh800, 12'sh7FF);
		send_beat(rwsc_pkg::CMD_CAST_RAY, 12'sh800, 12'sh800, 12'sh7FF, 12'sh7FF);

		// Pressure: receiver holds off while the sender offers walls.
		fork
			hold_receiver(400);
			for (int i = 0; i < 6; i++)
				send_beat(rwsc_pkg::CMD_ADD_WALL, rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord());
		join

		// Random: mostly walls until the table fills, then rays and
		// overflow attempts on the full table.
		for (int i = 0; i < 400; i++) begin
			if (sb.wall_cnt < 64 && $urandom_range(0, 1) == 0)
				send_beat(rwsc_pkg::CMD_ADD_WALL, rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord());
			else if ($urandom_range(0, 9) == 0)
				send_beat(rwsc_pkg::CMD_ADD_WALL, rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord());
			else
				send_beat(rwsc_pkg::CMD_CAST_RAY, rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord());
		end
		req.valid <= 1'b0;

		stim_done = 1'b1;
		quiet = 0;
		while (sb.pending() != 0 && quiet < 10000) begin
			@(posedge clk);
			quiet++;
		end
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS ray_wall_segment_clipper");
		else
			$display("FAIL ray_wall_segment_clipper");
		$finish;
	end

	// Worst case: ~430 items, a 12 ns clock, plus stalls, taken several times over.
	initial begin
		#60ms;
		$display("FAIL ray_wall_segment_clipper");
		$finish;
	end
endmodule
`default_nettype wire
